// ===== hdl/sawarq_pkg.sv =====
// Shared types, frame layout constants and parity helpers for the ARQ endpoint.
`timescale 1ns / 1ps

package sawarq_pkg;

	// Frame bit positions.
	localparam int unsigned FRM_PARITY = 15;
	localparam int unsigned FRM_SEQ    = 14;
	localparam int unsigned FRM_LAST   = 13;
	localparam int unsigned FRM_ACK    = 12;

	// Action codes of an input item.
	localparam logic [1:0] ACT_SEND = 2'd0;
	localparam logic [1:0] ACT_ACK  = 2'd1;
	localparam logic [1:0] ACT_DATA = 2'd2;

	// Status codes of a result item.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_REFUSED  = 2'd1;
	localparam logic [1:0] ST_IDLE_ACK = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  data_byte;
		logic        last_flag;
		logic [15:0] frame_in;
	} req_item_t;

	typedef struct packed {
		logic        send;
		logic [15:0] frame;
		logic        done;
		logic [1:0]  status;
	} tx_res_t;

	typedef struct packed {
		logic        send;
		logic [15:0] frame;
		logic        deliver;
		logic [7:0]  rx_byte;
		logic        rx_last;
	} rx_res_t;

	// Build a frame from its fields and append even parity over bits 0 to 14.
	function automatic logic [15:0] seal_frame(logic seq, logic last, logic ack,
			logic [7:0] data);
		logic [14:0] body;
		body = {seq, last, ack, 4'b0000, data};
		return {^body, body};
	endfunction

	// A frame is intact when all sixteen bits have even parity.
	function automatic logic frame_intact(logic [15:0] frame);
		return ~(^frame);
	endfunction

endpackage

// ===== hdl/sawarq_ifs.sv =====
// Handshake channel interfaces for request and response items.
`timescale 1ns / 1ps

interface sawarq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  data_byte;
	logic        last_flag;
	logic [15:0] frame_in;

	modport source (output valid, action, data_byte, last_flag, frame_in, input ready);
	modport sink (input valid, action, data_byte, last_flag, frame_in, output ready);
endinterface

interface sawarq_rsp_if;
	logic        valid;
	logic        ready;
	logic        send_frame;
	logic [15:0] out_frame;
	logic        deliver;
	logic [7:0]  rx_byte;
	logic        rx_last;
	logic        tx_done;
	logic [1:0]  status;

	modport source (output valid, send_frame, out_frame, deliver, rx_byte, rx_last,
		tx_done, status, input ready);
	modport sink (input valid, send_frame, out_frame, deliver, rx_byte, rx_last,
		tx_done, status, output ready);
endinterface

// ===== hdl/sawarq_tx.sv =====
// Transmit side: framing, held frame, transmit sequence bit and ack checking.
`timescale 1ns / 1ps

module sawarq_tx import sawarq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      commit,
	input  req_item_t item,
	output tx_res_t   res
);

	logic        tx_seq_q;
	logic        awaiting_q;
	logic [15:0] held_frame_q;
	logic [15:0] new_frame;
	logic        ack_ok;
	logic        take_byte;
	logic        ack_done;

	assign new_frame = seal_frame(tx_seq_q, item.last_flag, 1'b0, item.data_byte);
	assign ack_ok = frame_intact(item.frame_in) && item.frame_in[FRM_ACK]
		&& (item.frame_in[FRM_SEQ] == tx_seq_q);
	assign take_byte = (item.action == ACT_SEND) && !awaiting_q;
	assign ack_done = (item.action == ACT_ACK) && awaiting_q && ack_ok;

	always_comb begin
		res = '0;
		case (item.action)
			ACT_SEND: begin
				if (awaiting_q) begin
					res.status = ST_REFUSED;
				end else begin
					res.send  = 1'b1;
					res.frame = new_frame;
				end
			end
			ACT_ACK: begin
				if (!awaiting_q) begin
					res.status = ST_IDLE_ACK;
				end else if (ack_ok) begin
					res.done = 1'b1;
				end else begin
					res.send  = 1'b1;
					res.frame = held_frame_q;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_seq_q   <= 1'b0;
			awaiting_q <= 1'b0;
		end else if (commit) begin
			if (take_byte) begin
				awaiting_q <= 1'b1;
			end else if (ack_done) begin
				awaiting_q <= 1'b0;
				tx_seq_q   <= ~tx_seq_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit && take_byte) begin
			held_frame_q <= new_frame;
		end
	end

endmodule

// ===== hdl/sawarq_rx.sv =====
// Receive side: I-frame checking, ACK/NAK answers and in-order delivery.
`timescale 1ns / 1ps

module sawarq_rx import sawarq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      commit,
	input  req_item_t item,
	output rx_res_t   res
);

	logic rx_expected_q;
	logic good;
	logic in_order;

	assign good = frame_intact(item.frame_in);
	assign in_order = (item.action == ACT_DATA) && good
		&& (item.frame_in[FRM_SEQ] == rx_expected_q);

	always_comb begin
		res = '0;
		if (item.action == ACT_DATA) begin
			res.send  = 1'b1;
			res.frame = seal_frame(item.frame_in[FRM_SEQ], 1'b0, good, 8'h00);
		end
		if (in_order) begin
			res.deliver = 1'b1;
			res.rx_byte = item.frame_in[7:0];
			res.rx_last = item.frame_in[FRM_LAST];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_expected_q <= 1'b0;
		end else if (commit && in_order) begin
			rx_expected_q <= ~rx_expected_q;
		end
	end

endmodule

// ===== hdl/stop_and_wait_arq_endpoint.sv =====
// Top level of the stop-and-wait ARQ endpoint: input register, both sides, result register.
// A request item passes through the input register into the result register, from which
// its result item is offered. Throughput: one item per cycle while the response channel
// is not stalled; a stall on the response channel reaches req.ready combinationally.
// Reset (arst_n, asynchronous, active low) clears both valid flags, the sequence
// bits and the waiting flag; the held frame is written before it is ever read.
`timescale 1ns / 1ps

module stop_and_wait_arq_endpoint import sawarq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sawarq_req_if.sink  req,
	sawarq_rsp_if.source rsp
);

	// Input register. An item waits here until the result register can take
	// its result; the protocol state is updated at that same edge, so items
	// always see the state left by the one before them.
	logic      v_s1;
	req_item_t item_s1;

	// Result register.
	logic        v_q;
	logic        send_q;
	logic [15:0] frame_q;
	logic        deliver_q;
	logic [7:0]  rx_byte_q;
	logic        rx_last_q;
	logic        done_q;
	logic [1:0]  status_q;

	logic    advance;
	tx_res_t tx_res;
	rx_res_t rx_res;

	// The staged item moves on when the result register is empty or is being
	// emptied in this cycle; the input register refills in the same cycle.
	assign advance   = v_s1 && (!v_q || rsp.ready);
	assign req.ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.action    <= req.action;
			item_s1.data_byte <= req.data_byte;
			item_s1.last_flag <= req.last_flag;
			item_s1.frame_in  <= req.frame_in;
		end
	end

	sawarq_tx u_tx (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.item   (item_s1),
		.res    (tx_res)
	);

	sawarq_rx u_rx (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.item   (item_s1),
		.res    (rx_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (advance) begin
			v_q <= 1'b1;
		end else if (rsp.ready) begin
			v_q <= 1'b0;
		end
	end

	// Each side returns all zeros for actions it does not own, so the two
	// results merge with an OR. The unused action code yields an all-zero item.
	always_ff @(posedge clk) begin
		if (advance) begin
			send_q    <= tx_res.send | rx_res.send;
			frame_q   <= tx_res.frame | rx_res.frame;
			deliver_q <= rx_res.deliver;
			rx_byte_q <= rx_res.rx_byte;
			rx_last_q <= rx_res.rx_last;
			done_q    <= tx_res.done;
			status_q  <= tx_res.status;
		end
	end

	assign rsp.valid      = v_q;
	assign rsp.send_frame = send_q;
	assign rsp.out_frame  = frame_q;
	assign rsp.deliver    = deliver_q;
	assign rsp.rx_byte    = rx_byte_q;
	assign rsp.rx_last    = rx_last_q;
	assign rsp.tx_done    = done_q;
	assign rsp.status     = status_q;

endmodule
